@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dsns_pkg.sv @@
// ----------------------------------------------------------------------------
// dsns_pkg
// Constants, character codes and scale tables for the decimal timestamp
// to nanoseconds converter.
// ----------------------------------------------------------------------------
package dsns_pkg;

  // Fraction digits accepted, and digits of a nanosecond fraction
  localparam int FRAC_DIGITS = 9;
  localparam int NS_DIGITS   = 9;

  localparam int CHAR_W  = 8;
  localparam int SEC_W   = 34;
  localparam int NS_W    = 63;
  localparam int FRAC_W  = 30;
  localparam int CNT_W   = 4;
  localparam int DIGIT_W = 4;

  // Largest whole seconds that still fit a signed 64-bit nanosecond count
  localparam logic [SEC_W-1:0] SECONDS_LIMIT = 34'd9223372036;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2e;

  // Power of ten for a fraction digit position
  function automatic logic [FRAC_W-1:0] pow_ten(input logic [CNT_W-1:0] idx);
    logic [FRAC_W-1:0] p;
    case (idx)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  // One whole-second digit scaled to nanoseconds
  function automatic logic [NS_W-1:0] digit_sec_ns(input logic [DIGIT_W-1:0] d);
    logic [NS_W-1:0] v;
    case (d)
      4'd0:    v = 63'd0;
      4'd1:    v = 63'd1000000000;
      4'd2:    v = 63'd2000000000;
      4'd3:    v = 63'd3000000000;
      4'd4:    v = 63'd4000000000;
      4'd5:    v = 63'd5000000000;
      4'd6:    v = 63'd6000000000;
      4'd7:    v = 63'd7000000000;
      4'd8:    v = 63'd8000000000;
      4'd9:    v = 63'd9000000000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/decimal_seconds_to_nanoseconds.sv @@
// ----------------------------------------------------------------------------
// decimal_seconds_to_nanoseconds
// Parses a decimal timestamp text, one ASCII character per transaction, into
// a nanosecond count with a validity flag.
// ----------------------------------------------------------------------------
// The block takes one character per cycle unless the input side stalls, and raises
// out_tvalid once the transaction carrying tlast has passed the input register and
// the finish register into the result register. Characters pass an input register,
// then update the running state: the whole seconds are kept both as a count and
// already scaled to nanoseconds, and each fraction digit is scaled by its power of
// ten as it arrives, so each whole-second step is a multiply-by-ten accumulate. On
// the last character the finished values move to a finish register, and the result
// stage adds seconds and fraction and checks the sum against the signed 64-bit
// limit. The input side stalls only when a last character meets a full finish
// register and a result that is not taken. out_tuser is the ok flag; out_tdata is
// zero when ok is low.
`include "assert_macros.svh"

module decimal_seconds_to_nanoseconds (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // last character of the text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [62:0] nanoseconds, [63] zero
  output logic        out_tuser   // [0] ok
);
  import dsns_pkg::*;

  // Input register
  logic                in_valid_r;
  logic [CHAR_W-1:0]   ch_r;
  logic                last_r;

  // Running parse state
  logic                in_frac_r, in_frac_nxt;
  logic                seen_r, seen_nxt;
  logic [SEC_W-1:0]    sec_r, sec_nxt;
  logic [NS_W-1:0]     sec_ns_r, sec_ns_nxt;
  logic                over_r, over_nxt;
  logic [FRAC_W-1:0]   frac_ns_r, frac_ns_nxt;
  logic [CNT_W-1:0]    frac_cnt_r, frac_cnt_nxt;
  logic                bad_r, bad_nxt;

  // Finish register
  logic                fin_valid_r;
  logic                fin_ok_r;
  logic [NS_W-1:0]     fin_sec_ns_r;
  logic [FRAC_W-1:0]   fin_frac_r;

  // Result register
  logic                out_valid_r;
  logic                out_ok_r;
  logic [NS_W-1:0]     out_ns_r;

  logic                out_ready;
  logic                fin_ready;
  logic                s1_move;
  logic                is_digit;
  logic [DIGIT_W-1:0]  digit;
  logic [CHAR_W-1:0]   ch_off;
  logic [SEC_W+3:0]    sec_ext;
  logic [SEC_W+3:0]    sec_cand;
  logic [NS_W-1:0]     sec_ns_cand;
  logic [FRAC_W-1:0]   frac_add;
  logic                ok_pre;
  logic [NS_W:0]       sum;

  // Stage handshakes
  assign out_ready = !out_valid_r || out_tready;
  assign fin_ready = !fin_valid_r || out_ready;
  assign s1_move   = in_valid_r && (!last_r || fin_ready);
  assign in_tready = !in_valid_r || s1_move;

  // Decode the held character
  assign ch_off   = ch_r - CHAR_ZERO;
  assign digit    = ch_off[DIGIT_W-1:0];
  assign is_digit = ch_r inside {[CHAR_ZERO:CHAR_NINE]};

  // Candidate accumulations
  assign sec_ext     = {4'd0, sec_r};
  assign sec_cand    = (sec_ext << 3) + (sec_ext << 1) + {{(SEC_W){1'b0}}, digit};
  assign sec_ns_cand = (sec_ns_r << 3) + (sec_ns_r << 1) + digit_sec_ns(digit);
  assign frac_add    = {{(FRAC_W-DIGIT_W){1'b0}}, digit}
                       * pow_ten(CNT_W'(NS_DIGITS - 1) - frac_cnt_r);

  // Advance the parse state by one character
  always_comb begin
    in_frac_nxt  = in_frac_r;
    seen_nxt     = seen_r;
    sec_nxt      = sec_r;
    sec_ns_nxt   = sec_ns_r;
    over_nxt     = over_r;
    frac_ns_nxt  = frac_ns_r;
    frac_cnt_nxt = frac_cnt_r;
    bad_nxt      = bad_r;
    if (is_digit) begin
      if (!in_frac_r) begin
        seen_nxt = 1'b1;
        if (over_r || (sec_cand > {4'd0, SECONDS_LIMIT})) begin
          over_nxt = 1'b1;
        end else begin
          sec_nxt    = sec_cand[SEC_W-1:0];
          sec_ns_nxt = sec_ns_cand;
        end
      end else if (frac_cnt_r >= CNT_W'(FRAC_DIGITS)) begin
        bad_nxt = 1'b1;
      end else begin
        frac_ns_nxt  = frac_ns_r + frac_add;
        frac_cnt_nxt = frac_cnt_r + 1'b1;
      end
    end else if (ch_r == CHAR_DOT) begin
      if (in_frac_r || !seen_r) begin
        bad_nxt = 1'b1;
      end
      in_frac_nxt = 1'b1;
    end else begin
      bad_nxt = 1'b1;
    end
  end

  assign ok_pre = !bad_nxt && !over_nxt && seen_nxt && !(in_frac_nxt && frac_cnt_nxt == '0);

  // Load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready) begin
      ch_r   <= in_tdata[CHAR_W-1:0];
      last_r <= in_tlast;
    end
  end

  // Update the parse state; clear it after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_move && last_r)) begin
      in_frac_r  <= 1'b0;
      seen_r     <= 1'b0;
      sec_r      <= '0;
      sec_ns_r   <= '0;
      over_r     <= 1'b0;
      frac_ns_r  <= '0;
      frac_cnt_r <= '0;
      bad_r      <= 1'b0;
    end else if (s1_move) begin
      in_frac_r  <= in_frac_nxt;
      seen_r     <= seen_nxt;
      sec_r      <= sec_nxt;
      sec_ns_r   <= sec_ns_nxt;
      over_r     <= over_nxt;
      frac_ns_r  <= frac_ns_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      bad_r      <= bad_nxt;
    end
  end

  // Capture the finished values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_ready) begin
      fin_valid_r <= s1_move && last_r;
    end
    if (fin_ready) begin
      fin_ok_r     <= ok_pre;
      fin_sec_ns_r <= sec_ns_nxt;
      fin_frac_r   <= frac_ns_nxt;
    end
  end

  // Add seconds and fraction, reject a sum past the signed limit
  assign sum = {1'b0, fin_sec_ns_r} + {{(NS_W+1-FRAC_W){1'b0}}, fin_frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= fin_valid_r;
    end
    if (out_ready) begin
      out_ok_r <= fin_ok_r && !sum[NS_W];
      out_ns_r <= (fin_ok_r && !sum[NS_W]) ? sum[NS_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {1'b0, out_ns_r};

  // Assertions
  `ASSERT_NEXT(a_fin_to_out, fin_valid_r && out_ready, out_valid_r,
               "finished item did not reach the result register")
  `ASSERT_NEXT(a_clear_after_last, s1_move && last_r,
               !in_frac_r && !seen_r && frac_cnt_r == '0 && sec_r == '0,
               "parse state not cleared after last character")
  `ASSERT_IMPL(a_whole_part_no_frac, !in_frac_r, frac_cnt_r == '0 && frac_ns_r == '0,
               "fraction state set before a dot")
  `ASSERT_IMPL(a_reject_zero, out_valid_r && !out_ok_r, out_ns_r == '0,
               "rejected result carries a nonzero value")

endmodule
